>>> hw/rtl/uce_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uce_pkg
// Shared types, constants and helper functions of the unicode escape to
// code page 866 decoder.
// ----------------------------------------------------------------------------
package uce_pkg;

  localparam logic [7:0]  CH_BACKSLASH = 8'd92;
  localparam logic [7:0]  CH_U         = 8'd117;

  localparam logic [15:0] CODE_IO      = 16'd1025;
  localparam logic [15:0] CODE_YO      = 16'd1105;
  localparam logic [15:0] CODE_SPLIT   = 16'd1088;
  localparam logic [15:0] OFS_LOW      = 16'd912;
  localparam logic [15:0] OFS_HIGH     = 16'd864;
  localparam logic [7:0]  CP_IO        = 8'd240;
  localparam logic [7:0]  CP_YO        = 8'd241;

  localparam int unsigned FIFO_DEPTH   = 3;
  localparam int unsigned FIFO_AW      = 2;

  typedef enum logic [2:0] {
    PH_NORMAL = 3'd0,
    PH_BSLASH = 3'd1,
    PH_HEX0   = 3'd2,
    PH_HEX1   = 3'd3,
    PH_HEX2   = 3'd4,
    PH_HEX3   = 3'd5
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] code_accum;
    logic        digits_valid;
  } dec_state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic [1:0] n;
    out_word_t  w0;
    out_word_t  w1;
  } step_res_t;

  typedef struct packed {
    logic [1:0] count;
  } fifo_stat_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_value(input logic [7:0] b);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (b inside {[8'd48:8'd57]}) begin
      h.val = 4'(b - 8'd48);
    end else if (b inside {[8'd97:8'd102]}) begin
      h.val = 4'(b - 8'd87);
    end else if (b inside {[8'd65:8'd70]}) begin
      h.val = 4'(b - 8'd55);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic logic [7:0] map_code(input logic [15:0] v);
    logic [15:0] d;
    if (v == CODE_IO) begin
      return CP_IO;
    end else if (v == CODE_YO) begin
      return CP_YO;
    end else begin
      d = (v < CODE_SPLIT) ? (v - OFS_LOW) : (v - OFS_HIGH);
      return d[7:0];
    end
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/uce_stream_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uce_in_if / uce_out_if
// Valid/ready stream channels for the escaped text and the decoded bytes.
// ----------------------------------------------------------------------------
interface uce_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface uce_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/uce_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uce_step
// Next decoder state and up to two output words for one input byte.
// ----------------------------------------------------------------------------
module uce_step import uce_pkg::*; (
  input  wire dec_state_t  cur,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last,
  output dec_state_t       nxt,
  output step_res_t        res
);

  hex_t        h;
  logic [15:0] acc_new;

  always_comb begin
    h       = hex_value(in_byte);
    acc_new = cur.code_accum;
    nxt     = cur;
    res     = '0;

    case (cur.phase)
      PH_BSLASH: begin
        if (in_byte == CH_U) begin
          nxt.code_accum   = '0;
          nxt.digits_valid = 1'b1;
          if (in_last) begin
            res.n    = 2'd1;
            res.w0   = '{data: map_code(16'd0), last: 1'b1};
            nxt.phase = PH_NORMAL;
          end else begin
            nxt.phase = PH_HEX0;
          end
        end else begin
          // release the held backslash, then treat the byte as plain text
          res.w0 = '{data: CH_BACKSLASH, last: 1'b0};
          res.n  = 2'd1;
          if (in_byte == CH_BACKSLASH && !in_last) begin
            nxt.phase = PH_BSLASH;
          end else begin
            res.w1    = '{data: in_byte, last: in_last};
            res.n     = 2'd2;
            nxt.phase = PH_NORMAL;
          end
        end
      end
      PH_HEX0, PH_HEX1, PH_HEX2, PH_HEX3: begin
        if (cur.digits_valid && h.ok) begin
          acc_new = {cur.code_accum[11:0], h.val};
        end else begin
          nxt.digits_valid = 1'b0;
        end
        nxt.code_accum = acc_new;
        if (cur.phase == PH_HEX3 || in_last) begin
          res.n     = 2'd1;
          res.w0    = '{data: map_code(acc_new), last: in_last};
          nxt.phase = PH_NORMAL;
        end else begin
          case (cur.phase)
            PH_HEX0: nxt.phase = PH_HEX1;
            PH_HEX1: nxt.phase = PH_HEX2;
            default: nxt.phase = PH_HEX3;
          endcase
        end
      end
      default: begin
        if (in_byte == CH_BACKSLASH && !in_last) begin
          nxt.phase = PH_BSLASH;
        end else begin
          res.n     = 2'd1;
          res.w0    = '{data: in_byte, last: in_last};
          nxt.phase = PH_NORMAL;
        end
      end
    endcase

    if (in_last) begin
      nxt.phase        = PH_NORMAL;
      nxt.code_accum   = '0;
      nxt.digits_valid = 1'b1;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/uce_out_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uce_out_fifo
// Three-word result queue; takes up to two words per cycle, gives one.
// ----------------------------------------------------------------------------
module uce_out_fifo import uce_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire step_res_t push,
  input  wire logic      pop,
  output out_word_t      head_word,
  output logic           not_empty,
  output fifo_stat_t     stat
);

  out_word_t          mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] head_r, head_nxt;
  logic [FIFO_AW-1:0] tail_r, tail_nxt;
  logic [1:0]         count_r, count_nxt;

  function automatic logic [FIFO_AW-1:0] wrap_inc(input logic [FIFO_AW-1:0] p);
    return (p == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    head_nxt  = pop ? wrap_inc(head_r) : head_r;
    case (push.n)
      2'd1:    tail_nxt = wrap_inc(tail_r);
      2'd2:    tail_nxt = wrap_inc(wrap_inc(tail_r));
      default: tail_nxt = tail_r;
    endcase
    count_nxt = count_r + push.n - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[tail_r] <= push.w0;
    end
    if (push.n == 2'd2) begin
      mem_r[wrap_inc(tail_r)] <= push.w1;
    end
  end

  assign head_word  = mem_r[head_r];
  assign not_empty  = (count_r != 2'd0);
  assign stat.count = count_r;

endmodule
`default_nettype wire

>>> hw/rtl/unicode_escape_to_cp866_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// unicode_escape_to_cp866_unit
// Decodes backslash-u hex escapes in a byte stream to code page 866 bytes.
// ----------------------------------------------------------------------------
// Results are registered in the result queue and offered in input order.
// Throughput: one input word per cycle while each word gives at most one
// result and out_ch is not stalled; a word with two results (backslash not
// followed by 'u') holds off input, as the output port gives one per cycle.
// Reset (rst_n low, synchronous): decoder returns to plain text, nothing
// held, escape value zero; the result queue is emptied.
module unicode_escape_to_cp866_unit import uce_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  uce_in_if.sink     in_ch,
  uce_out_if.source  out_ch
);

  // decoder state: phase, escape value being built, digit run still valid
  dec_state_t state_r, state_nxt;
  step_res_t  step_res;
  step_res_t  push;
  fifo_stat_t fq_stat;
  out_word_t  head_word;
  logic       fq_not_empty;
  logic       in_acc;
  logic       out_acc;

  // take a word only when the queue has room for two results
  assign in_ch.ready = (fq_stat.count <= 2'd1);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_acc     = out_ch.valid && out_ch.ready;

  uce_step u_step (
    .cur     (state_r),
    .in_byte (in_ch.in_byte),
    .in_last (in_ch.in_last),
    .nxt     (state_nxt),
    .res     (step_res)
  );

  // push nothing when no word is taken
  always_comb begin
    push = step_res;
    if (!in_acc) begin
      push.n = 2'd0;
    end
  end

  // advance the decoder state only on an accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: PH_NORMAL, code_accum: 16'd0, digits_valid: 1'b1};
    end else if (in_acc) begin
      state_r <= state_nxt;
    end
  end

  // results wait here, so the input side keeps moving while output stalls
  uce_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (out_acc),
    .head_word (head_word),
    .not_empty (fq_not_empty),
    .stat      (fq_stat)
  );

  assign out_ch.valid    = fq_not_empty;
  assign out_ch.out_byte = head_word.data;
  assign out_ch.out_last = head_word.last;

  // every final byte produces at least one result
  a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.in_last) |-> (step_res.n != 2'd0))
    else $error("final input word produced no result");

  // the string end always brings the decoder back to plain text
  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.in_last) |=> (state_r.phase == PH_NORMAL &&
                                   state_r.code_accum == 16'd0 &&
                                   state_r.digits_valid))
    else $error("decoder state not cleared after final word");

  // queue never overfills: count can only grow when there was room
  a_fifo_room: assert property (@(posedge clk) disable iff (!rst_n)
    (fq_stat.count == 2'd3) |-> $past(fq_stat.count) != 2'd3 || !$past(in_acc))
    else $error("result queue overflow");

  // a two-result step only follows a held backslash
  a_two_only_bslash: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && step_res.n == 2'd2) |-> (state_r.phase == PH_BSLASH))
    else $error("two results outside a held backslash");

endmodule
`default_nettype wire

>>> verif/unicode_escape_to_cp866_unit_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// unicode_escape_to_cp866_unit_tb
// Self-checking bench for the escape decoder. A short table of hand-picked
// words comes first. It covers the byte extremes, both special code points,
// a backslash without 'u', escapes cut short at the end of a string, and a
// non-hex byte inside the digits. A long random stream follows; its largest
// share is well-formed escapes with random codes, mixed with plain text and
// broken escapes. Each output word is compared in order against the words of
// the bench-side decoder for every accepted word, or a typed row's own word.
// ----------------------------------------------------------------------------
module unicode_escape_to_cp866_unit_tb;
  import uce_pkg::*;

  localparam int unsigned DIRECTED_ROWS = 25;
  localparam int unsigned RANDOM_ITEMS  = 1650;
  localparam int unsigned PAUSE_AT      = DIRECTED_ROWS + 900;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned CYCLE_LIMIT   = 700000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } cp_word_t;

  // What one input word produces: zero, one or two output words.
  typedef struct {
    int unsigned count;
    cp_word_t    word [2];
  } decoded_t;

  // One line of the directed table. When typed is set, the output word is
  // given by hand. Otherwise the bench decoder supplies it.
  typedef struct packed {
    logic [7:0] text;
    logic       last;
    bit         typed;
    cp_word_t   word;
  } text_row_t;

  logic clk;
  logic rst_n;

  uce_in_if  in_ch ();
  uce_out_if out_ch ();

  unicode_escape_to_cp866_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Bench copy of the decoder state.
  phase_t      dec_phase     = PH_NORMAL;
  logic [15:0] dec_accum     = '0;
  logic        dec_digits_ok = 1'b1;

  cp_word_t    expected_words [$];
  cp_word_t    want_word;
  int unsigned mismatch_count = 0;
  int unsigned sent_count     = 0;
  int unsigned cycle_count    = 0;
  bit          starve_request = 1'b0;

  // Directed table. Several rows are escapes whose words only make sense
  // together, so read the table in groups.
  text_row_t directed_rows [DIRECTED_ROWS] = '{
    '{8'h00,        1'b0, 1'b1, '{8'h00, 1'b0}},  // NUL passes as plain text
    '{8'hFF,        1'b1, 1'b1, '{8'hFF, 1'b1}},  // top byte, string ends
    '{CH_BACKSLASH, 1'b0, 1'b0, '0},              // \u0401 gives the IO letter
    '{CH_U,         1'b0, 1'b0, '0},
    '{"0",          1'b0, 1'b0, '0},
    '{"4",          1'b0, 1'b0, '0},
    '{"0",          1'b0, 1'b0, '0},
    '{"1",          1'b0, 1'b1, '{CP_IO, 1'b0}},
    '{CH_BACKSLASH, 1'b0, 1'b0, '0},              // \u0451 ends the string
    '{CH_U,         1'b0, 1'b0, '0},
    '{"0",          1'b0, 1'b0, '0},
    '{"4",          1'b0, 1'b0, '0},
    '{"5",          1'b0, 1'b0, '0},
    '{"1",          1'b1, 1'b1, '{CP_YO, 1'b1}},
    '{CH_BACKSLASH, 1'b0, 1'b0, '0},              // backslash, then 'x'
    '{"x",          1'b0, 1'b0, '0},
    '{CH_BACKSLASH, 1'b0, 1'b0, '0},              // held backslash at the end
    '{CH_BACKSLASH, 1'b1, 1'b0, '0},
    '{CH_BACKSLASH, 1'b0, 1'b0, '0},              // lone backslash-u at the end
    '{CH_U,         1'b1, 1'b1, '{8'd112, 1'b1}},
    '{CH_BACKSLASH, 1'b0, 1'b0, '0},              // non-hex cuts a short escape
    '{CH_U,         1'b0, 1'b0, '0},
    '{"F",          1'b0, 1'b0, '0},
    '{"g",          1'b1, 1'b0, '0},
    '{CH_BACKSLASH, 1'b1, 1'b1, '{CH_BACKSLASH, 1'b1}}  // backslash as last byte
  };

  // --------------------------------------------------------------------------
  // Bench-side decoder
  // --------------------------------------------------------------------------
  function automatic bit nibble_of(input logic [7:0] c, output logic [3:0] v);
    v = '0;
    if (c >= "0" && c <= "9") begin
      v = 4'(c - "0");
      return 1'b1;
    end
    if (c >= "a" && c <= "f") begin
      v = 4'(c - "a" + 8'd10);
      return 1'b1;
    end
    if (c >= "A" && c <= "F") begin
      v = 4'(c - "A" + 8'd10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Code point to code page 866. The two special letters are tested before
  // the range split, since 1105 would otherwise fall in the upper range.
  function automatic logic [7:0] cp866_of(input logic [15:0] code);
    logic [15:0] shifted;
    if (code == CODE_IO) return CP_IO;
    if (code == CODE_YO) return CP_YO;
    shifted = (code >= CODE_SPLIT) ? code - OFS_HIGH : code - OFS_LOW;
    return shifted[7:0];
  endfunction

  function automatic void add_word(inout decoded_t r, input logic [7:0] b, input logic l);
    r.word[r.count] = '{b, l};
    r.count++;
  endfunction

  // Plain-text handling: hold a backslash unless the string ends on it.
  function automatic void pass_byte(inout decoded_t r, input logic [7:0] b, input logic l);
    if (b == CH_BACKSLASH && !l) begin
      dec_phase = PH_BSLASH;
    end else begin
      add_word(r, b, l);
      dec_phase = PH_NORMAL;
    end
  endfunction

  function automatic decoded_t decode_step(input logic [7:0] b, input logic l);
    decoded_t   r;
    logic [3:0] nib;
    bit         is_hex;
    r.count = 0;
    r.word[0] = '0;
    r.word[1] = '0;
    case (dec_phase)
      PH_BSLASH: begin
        if (b == CH_U) begin
          dec_accum     = '0;
          dec_digits_ok = 1'b1;
          if (l) begin
            add_word(r, cp866_of(dec_accum), 1'b1);
            dec_phase = PH_NORMAL;
          end else begin
            dec_phase = PH_HEX0;
          end
        end else begin
          // Release the held backslash, then treat this byte as plain text.
          add_word(r, CH_BACKSLASH, 1'b0);
          pass_byte(r, b, l);
        end
      end
      PH_HEX0, PH_HEX1, PH_HEX2, PH_HEX3: begin
        is_hex = nibble_of(b, nib);
        // Once a non-hex byte shows up, freeze the value but keep counting.
        if (dec_digits_ok && is_hex) begin
          dec_accum = {dec_accum[11:0], nib};
        end else begin
          dec_digits_ok = 1'b0;
        end
        if (dec_phase == PH_HEX3 || l) begin
          add_word(r, cp866_of(dec_accum), l);
          dec_phase = PH_NORMAL;
        end else begin
          dec_phase = phase_t'(dec_phase + 3'd1);
        end
      end
      default: begin
        pass_byte(r, b, l);
      end
    endcase
    if (l) begin
      dec_phase     = PH_NORMAL;
      dec_accum     = '0;
      dec_digits_ok = 1'b1;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Mostly back-to-back. Sometimes a short gap, and rarely a long one.
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] pick_code();
    case ($urandom_range(0, 19))
      0:       return CODE_IO;
      1:       return CODE_YO;
      2:       return CODE_SPLIT;
      3:       return CODE_SPLIT - 16'd1;
      4:       return 16'h0000;
      5:       return 16'hFFFF;
      6, 7, 8, 9, 10: return 16'($urandom_range(1024, 1119));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
    if (n < 4'd10) return "0" + 8'(n);
    return (upper ? "A" : "a") + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex();
    if ($urandom_range(0, 2) == 0) return 8'($urandom_range(0, 47));
    return 8'($urandom_range(103, 255));
  endfunction

  // Offer one word, wait for the handshake, then record what it should give.
  // Must be called at a rising edge.
  task automatic send_word(input logic [7:0] b, input logic l,
                           input bit typed, input cp_word_t typed_word);
    int unsigned gap;
    decoded_t    res;
    // Run calm (no gaps) for one stretch of 128 words out of every three.
    gap = pick_gap(((sent_count >> 7) % 3) == 2);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_last <= l;
    do @(posedge clk); while (!in_ch.ready);
    res = decode_step(b, l);
    if (typed) begin
      expected_words.push_back(typed_word);
    end else begin
      for (int i = 0; i < res.count; i++) expected_words.push_back(res.word[i]);
    end
    sent_count++;
  endtask

  task automatic send_text(input logic [7:0] b, input logic l);
    send_word(b, l, 1'b0, '0);
  endtask

  // Positions: 0 backslash, 1 'u', 2..5 digits. Stop after stop_at, putting
  // the end-of-string flag there if asked. bad_pos picks a digit to spoil.
  task automatic send_escape(input logic [15:0] code, input int bad_pos,
                             input int stop_at, input bit last_at_stop);
    logic [7:0] c;
    for (int p = 0; p <= stop_at; p++) begin
      if (p == 0) begin
        c = CH_BACKSLASH;
      end else if (p == 1) begin
        c = CH_U;
      end else if (p - 2 == bad_pos) begin
        c = non_hex();
      end else begin
        c = hex_char(code[(5 - p) * 4 + 3 -: 4], 1'($urandom_range(0, 1)));
      end
      send_text(c, last_at_stop && p == stop_at);
    end
  endtask

  // --------------------------------------------------------------------------
  // Clock, cycle limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random back-pressure, plus one long hold on request
  // --------------------------------------------------------------------------
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (starve_request) begin
        starve_request = 1'b0;
        hold_left      = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        // Keep ready low long enough for the result queue to fill.
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        // One window out of every four, taken from the upper bits of cycle_count, runs without stalls.
        stall_left = pick_gap((cycle_count >> 8) % 4 == 3);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output checker: compare each accepted word with the oldest expected one
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: extra word, expected none, actual byte %0d last %0d",
                 $time, out_ch.out_byte, out_ch.out_last);
        mismatch_count++;
      end else begin
        want_word = expected_words.pop_front();
        if (out_ch.out_byte !== want_word.data) begin
          $display("%0t: out_byte mismatch, expected %0d, actual %0d",
                   $time, want_word.data, out_ch.out_byte);
          mismatch_count++;
        end
        if (out_ch.out_last !== want_word.last) begin
          $display("%0t: out_last mismatch, expected %0d, actual %0d",
                   $time, want_word.last, out_ch.out_last);
          mismatch_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence: reset, directed table, random stream, drain
  // --------------------------------------------------------------------------
  initial begin
    int unsigned r;
    bit          paused;
    paused = 1'b0;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.in_byte  <= '0;
    in_ch.in_last  <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table.
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_word(directed_rows[i].text, directed_rows[i].last,
                directed_rows[i].typed, directed_rows[i].word);
    end

    // Open the random part with a long receiver hold. The sender keeps
    // offering words, so the block fills up and drops in_ch.ready.
    starve_request = 1'b1;

    while (sent_count < DIRECTED_ROWS + RANDOM_ITEMS) begin
      if (!paused && sent_count >= PAUSE_AT) begin
        // Pause the sender until every pending word has come out.
        paused = 1'b1;
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (expected_words.size() != 0);
      end
      r = $urandom_range(0, 99);
      if (r < 45) begin
        // Well-formed escape. Now and then, cut it short at the end of a string.
        if ($urandom_range(0, 11) == 0) begin
          send_escape(pick_code(), -1, $urandom_range(0, 4), 1'b1);
        end else begin
          send_escape(pick_code(), -1, 5, $urandom_range(0, 5) == 0);
        end
      end else if (r < 65) begin
        // Plain text of arbitrary bytes.
        repeat ($urandom_range(1, 8)) begin
          send_text(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
        end
      end else if (r < 78) begin
        // Backslash followed by any byte.
        send_text(CH_BACKSLASH, 1'b0);
        send_text(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end else if (r < 90) begin
        // Escape with one spoiled digit.
        send_escape(pick_code(), $urandom_range(0, 3), 5, $urandom_range(0, 5) == 0);
      end else begin
        // Backslash released by the backslash of a real escape.
        send_text(CH_BACKSLASH, 1'b0);
        send_escape(pick_code(), -1, 5, $urandom_range(0, 3) == 0);
      end
    end

    // Drain, then wait out DRAIN_CYCLES so that any extra word shows up.
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_words.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> filelist.f
hw/rtl/uce_pkg.sv
hw/rtl/uce_stream_if.sv
hw/rtl/uce_step.sv
hw/rtl/uce_out_fifo.sv
hw/rtl/unicode_escape_to_cp866_unit.sv
verif/unicode_escape_to_cp866_unit_tb.sv
